// ===== hw/rtl/tvs_pkg.sv =====
// ----------------------------------------------------------------------------
// tvs_pkg
// Shared types, constants and arithmetic helpers of the vorticity step solver.
// ----------------------------------------------------------------------------
package tvs_pkg;

  // payload widths
  localparam int VAL_W  = 32;
  localparam int IDX_W  = 6;
  localparam int MA_W   = 33;
  localparam int MB_W   = 32;
  localparam int PROD_W = MA_W + MB_W;
  localparam int MR_W   = 48;
  localparam int ACC_W  = 50;
  localparam int ROM_AW = 6;
  localparam int ROM_N  = 64;

  // rounding shifts
  localparam logic [5:0] SH_HALF = 6'd21;
  localparam logic [5:0] SH_FULL = 6'd20;
  localparam logic [5:0] SH_FRAC = 6'd32;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_STEP_RATIO    = 2'd0,
    REG_DX_SQUARED    = 2'd1,
    REG_FORWARD_MODE  = 2'd2,
    REG_POINTS_IN_USE = 2'd3
  } reg_idx_t;

  // item function codes
  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_STEP = 1'b1
  } func_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_RD2,
    ST_M1,
    ST_Z,
    ST_ZM,
    ST_D,
    ST_DM,
    ST_S,
    ST_B0,
    ST_B1,
    ST_BRD,
    ST_BW,
    ST_CRD,
    ST_COUT
  } state_t;

  // off-diagonal magnitudes, entry k = round((k+1) * 2^32 / (k+2))
  localparam logic [MB_W-1:0] OFF_ROM [ROM_N] = '{
    32'((64'd4294967296 * 1 + 2 / 2) / 2),
    32'((64'd4294967296 * 2 + 3 / 2) / 3),
    32'((64'd4294967296 * 3 + 4 / 2) / 4),
    32'((64'd4294967296 * 4 + 5 / 2) / 5),
    32'((64'd4294967296 * 5 + 6 / 2) / 6),
    32'((64'd4294967296 * 6 + 7 / 2) / 7),
    32'((64'd4294967296 * 7 + 8 / 2) / 8),
    32'((64'd4294967296 * 8 + 9 / 2) / 9),
    32'((64'd4294967296 * 9 + 10 / 2) / 10),
    32'((64'd4294967296 * 10 + 11 / 2) / 11),
    32'((64'd4294967296 * 11 + 12 / 2) / 12),
    32'((64'd4294967296 * 12 + 13 / 2) / 13),
    32'((64'd4294967296 * 13 + 14 / 2) / 14),
    32'((64'd4294967296 * 14 + 15 / 2) / 15),
    32'((64'd4294967296 * 15 + 16 / 2) / 16),
    32'((64'd4294967296 * 16 + 17 / 2) / 17),
    32'((64'd4294967296 * 17 + 18 / 2) / 18),
    32'((64'd4294967296 * 18 + 19 / 2) / 19),
    32'((64'd4294967296 * 19 + 20 / 2) / 20),
    32'((64'd4294967296 * 20 + 21 / 2) / 21),
    32'((64'd4294967296 * 21 + 22 / 2) / 22),
    32'((64'd4294967296 * 22 + 23 / 2) / 23),
    32'((64'd4294967296 * 23 + 24 / 2) / 24),
    32'((64'd4294967296 * 24 + 25 / 2) / 25),
    32'((64'd4294967296 * 25 + 26 / 2) / 26),
    32'((64'd4294967296 * 26 + 27 / 2) / 27),
    32'((64'd4294967296 * 27 + 28 / 2) / 28),
    32'((64'd4294967296 * 28 + 29 / 2) / 29),
    32'((64'd4294967296 * 29 + 30 / 2) / 30),
    32'((64'd4294967296 * 30 + 31 / 2) / 31),
    32'((64'd4294967296 * 31 + 32 / 2) / 32),
    32'((64'd4294967296 * 32 + 33 / 2) / 33),
    32'((64'd4294967296 * 33 + 34 / 2) / 34),
    32'((64'd4294967296 * 34 + 35 / 2) / 35),
    32'((64'd4294967296 * 35 + 36 / 2) / 36),
    32'((64'd4294967296 * 36 + 37 / 2) / 37),
    32'((64'd4294967296 * 37 + 38 / 2) / 38),
    32'((64'd4294967296 * 38 + 39 / 2) / 39),
    32'((64'd4294967296 * 39 + 40 / 2) / 40),
    32'((64'd4294967296 * 40 + 41 / 2) / 41),
    32'((64'd4294967296 * 41 + 42 / 2) / 42),
    32'((64'd4294967296 * 42 + 43 / 2) / 43),
    32'((64'd4294967296 * 43 + 44 / 2) / 44),
    32'((64'd4294967296 * 44 + 45 / 2) / 45),
    32'((64'd4294967296 * 45 + 46 / 2) / 46),
    32'((64'd4294967296 * 46 + 47 / 2) / 47),
    32'((64'd4294967296 * 47 + 48 / 2) / 48),
    32'((64'd4294967296 * 48 + 49 / 2) / 49),
    32'((64'd4294967296 * 49 + 50 / 2) / 50),
    32'((64'd4294967296 * 50 + 51 / 2) / 51),
    32'((64'd4294967296 * 51 + 52 / 2) / 52),
    32'((64'd4294967296 * 52 + 53 / 2) / 53),
    32'((64'd4294967296 * 53 + 54 / 2) / 54),
    32'((64'd4294967296 * 54 + 55 / 2) / 55),
    32'((64'd4294967296 * 55 + 56 / 2) / 56),
    32'((64'd4294967296 * 56 + 57 / 2) / 57),
    32'((64'd4294967296 * 57 + 58 / 2) / 58),
    32'((64'd4294967296 * 58 + 59 / 2) / 59),
    32'((64'd4294967296 * 59 + 60 / 2) / 60),
    32'((64'd4294967296 * 60 + 61 / 2) / 61),
    32'((64'd4294967296 * 61 + 62 / 2) / 62),
    32'((64'd4294967296 * 62 + 63 / 2) / 63),
    32'((64'd4294967296 * 63 + 64 / 2) / 64),
    32'((64'd4294967296 * 64 + 65 / 2) / 65)
  };

  // round a sign-magnitude product at shift sh, ties away from zero
  function automatic logic signed [MR_W-1:0] mul_round(input logic [PROD_W-1:0] prod,
                                                       input logic neg,
                                                       input logic [5:0] sh);
    logic [PROD_W:0] sum;
    logic [PROD_W:0] r;
    logic signed [MR_W-1:0] m;
    sum = {1'b0, prod} + ((PROD_W+1)'(1) << (sh - 6'd1));
    r = sum >> sh;
    m = $signed(MR_W'(r));
    return neg ? -m : m;
  endfunction

  // clamp to the signed 32-bit range
  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(33'sh0_7FFF_FFFF);
    lo = -ACC_W'(33'sh0_8000_0000);
    if (v > hi) return 32'sh7FFF_FFFF;
    if (v < lo) return 32'sh8000_0000;
    return VAL_W'(v);
  endfunction

endpackage

// ===== hw/rtl/tvs_ifs.sv =====
// ----------------------------------------------------------------------------
// tvs channel interfaces
// Command, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tvs_cmd_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [5:0]  point_index;
  logic [31:0] zeta_value;
  logic [31:0] psi_value;

  modport source (output valid, func, point_index, zeta_value, psi_value, input ready);
  modport sink   (input valid, func, point_index, zeta_value, psi_value, output ready);
endinterface

interface tvs_res_if;
  logic        valid;
  logic        ready;
  logic [5:0]  out_index;
  logic [31:0] psi_out;
  logic [31:0] zeta_out;
  logic        last;

  modport source (output valid, out_index, psi_out, zeta_out, last, input ready);
  modport sink   (input valid, out_index, psi_out, zeta_out, last, output ready);
endinterface

interface tvs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/tvs_ram.sv =====
// ----------------------------------------------------------------------------
// tvs_ram
// Single write, single read synchronous memory with registered read data.
// ----------------------------------------------------------------------------
module tvs_ram #(
  parameter int DEPTH = 64,
  parameter int W     = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/tvs_mul.sv =====
// ----------------------------------------------------------------------------
// tvs_mul
// Shared signed-by-unsigned multiplier, registered sign and magnitude product.
// ----------------------------------------------------------------------------
module tvs_mul
  import tvs_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MA_W-1:0]   a,
  input  logic        [MB_W-1:0]   b,
  output logic        [PROD_W-1:0] prod,
  output logic                     neg
);

  logic [MA_W-1:0] mag;

  // magnitude of the signed operand
  always_comb begin
    mag = a[MA_W-1] ? MA_W'(-a) : MA_W'(a);
  end

  // one product per cycle
  always_ff @(posedge clk) begin
    neg  <= a[MA_W-1];
    prod <= PROD_W'(mag) * PROD_W'(b);
  end

endmodule

// ===== hw/rtl/bounded_vorticity_step_tridiag_solver.sv =====
// ----------------------------------------------------------------------------
// bounded_vorticity_step_tridiag_solver
// One-dimensional vorticity time step followed by a tridiagonal Poisson sweep.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries items. A load item (func 0) writes psi and zeta of one point
//   and completes with no result. A step item (func 1) advances
//   one time step over n = clamp(points_in_use, 3, XDIM) points and returns
//   n result items on res, ascending index, last set on point n-1.
//   cfg writes registers 0..3 (ratio, dx squared, mode, point count); it is
//   always ready and must only be used while no step is running.
// Sequencing:
//   a step holds the sequencer from the acceptance of its item until its
//   last result is loaded into the output register: a combined vorticity and
//   forward elimination pass (one shared multiplier used three times per
//   point, state memories with one read port each), back substitution, then
//   readout of each point. A stalled res holds the readout. cmd is ready only
//   between steps, so no new item is taken while a step runs.
// Reset:
//   rst clears the sequencer, output valid and the registers to their
//   defaults. State memories are not cleared and hold nothing until loaded.
// Stall:
//   results sit in an output register; a stalled res holds the sequencer in
//   its readout state until the result is taken.
// ----------------------------------------------------------------------------
module bounded_vorticity_step_tridiag_solver
  import tvs_pkg::*;
#(
  parameter int XDIM = 64
) (
  input  logic       clk,
  input  logic       rst,
  tvs_cfg_if.sink    cfg,
  tvs_cmd_if.sink    cmd,
  tvs_res_if.source  res
);

  localparam int AW = $clog2(XDIM);
  localparam int CW = $clog2(XDIM + 1);

  state_t state, state_next;

  // configuration
  logic [30:0] step_ratio;
  logic [31:0] dx_squared;
  logic        forward_mode;
  logic [6:0]  points_in_use;

  // sequencer datapath
  logic [AW-1:0]          j;
  logic [CW-1:0]          n;
  logic signed [VAL_W-1:0] zsrc, zpold, pleft, znew, swprev, psinext;
  logic signed [MA_W-1:0]  tval;

  // output register
  logic             o_valid;
  logic [IDX_W-1:0] o_idx;
  logic [VAL_W-1:0] o_psi, o_zeta;
  logic             o_last;

  // memory ports
  logic             psi_we, zp_we, zbp_we, sw_we;
  logic [AW-1:0]    psi_waddr, zp_waddr, psi_raddr;
  logic [VAL_W-1:0] psi_wdata, zp_wdata, zbp_wdata, sw_wdata;
  logic [VAL_W-1:0] psi_rd, zp_rd, zbp_rd, sw_rd;

  // multiplier
  logic signed [MA_W-1:0] mul_a;
  logic [MB_W-1:0]        mul_b;
  logic [PROD_W-1:0]      prod;
  logic                   prod_neg;
  logic [5:0]             sh;
  logic signed [MR_W-1:0] mr;

  logic                    cmd_acc, load_ok, is_first, is_last, right_ok, out_load;
  logic [CW-1:0]           n_clamp;
  logic signed [VAL_W-1:0] z_val, sw_val, b_val;
  logic signed [ACC_W-1:0] d_full;

  assign cfg.ready = 1'b1;
  assign cmd.ready = (state == ST_IDLE);
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign load_ok   = (7'(cmd.point_index) < 7'(XDIM));

  // point count clamp
  always_comb begin
    if (points_in_use < 7'd3) begin
      n_clamp = CW'(3);
    end else if (points_in_use > 7'(XDIM)) begin
      n_clamp = CW'(XDIM);
    end else begin
      n_clamp = CW'(points_in_use);
    end
  end

  assign is_first = (j == '0);
  assign is_last  = ((CW'(j) + CW'(1)) == n);
  assign right_ok = ((CW'(j) + CW'(1)) < n);
  assign out_load = !o_valid || res.ready;

  // rounding and saturation of the multiplier output
  assign mr     = mul_round(prod, prod_neg, sh);
  assign z_val  = sat32(ACC_W'(zsrc) - ACC_W'(mr));
  assign d_full = ACC_W'(mr);
  assign sw_val = sat32(-ACC_W'(mr));
  assign b_val  = sat32(ACC_W'($signed(sw_rd)) + ACC_W'(mr));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_ratio    <= 31'd1048576;
      dx_squared    <= 32'd1048576;
      forward_mode  <= 1'b1;
      points_in_use <= 7'd64;
    end else if (cfg.valid && cfg.ready) begin
      unique case (reg_idx_t'(cfg.index))
        REG_STEP_RATIO:    step_ratio    <= cfg.data[30:0];
        REG_DX_SQUARED:    dx_squared    <= cfg.data;
        REG_FORWARD_MODE:  forward_mode  <= cfg.data[0];
        REG_POINTS_IN_USE: points_in_use <= cfg.data[6:0];
        default: ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, memory and multiplier controls
  always_comb begin
    state_next = state;
    psi_we     = 1'b0;
    zp_we      = 1'b0;
    zbp_we     = 1'b0;
    sw_we      = 1'b0;
    psi_waddr  = j;
    zp_waddr   = j;
    psi_wdata  = psi_rd;
    zp_wdata   = z_val;
    zbp_wdata  = zpold;
    sw_wdata   = sw_val;
    psi_raddr  = j;
    mul_a      = MA_W'(psinext);
    mul_b      = OFF_ROM[ROM_AW'(j)];
    sh         = SH_FRAC;
    unique case (state)
      ST_IDLE: begin
        if (cmd_acc) begin
          if (func_t'(cmd.func) == FUNC_STEP) begin
            state_next = ST_RD;
          end else if (load_ok) begin
            psi_we    = 1'b1;
            zp_we     = 1'b1;
            zbp_we    = 1'b1;
            psi_waddr = AW'(cmd.point_index);
            zp_waddr  = AW'(cmd.point_index);
            psi_wdata = cmd.psi_value;
            zp_wdata  = cmd.zeta_value;
            zbp_wdata = cmd.zeta_value;
          end
        end
      end
      ST_RD: begin
        psi_raddr  = AW'(j - AW'(1));
        state_next = ST_RD2;
      end
      ST_RD2: begin
        psi_raddr  = AW'(j + AW'(1));
        state_next = ST_M1;
      end
      ST_M1: begin
        mul_a      = (right_ok ? MA_W'($signed(psi_rd)) : '0) - MA_W'(pleft);
        mul_b      = MB_W'(step_ratio);
        state_next = ST_Z;
      end
      ST_Z: begin
        sh         = forward_mode ? SH_HALF : SH_FULL;
        zp_we      = 1'b1;
        zbp_we     = 1'b1;
        state_next = ST_ZM;
      end
      ST_ZM: begin
        mul_a      = MA_W'(znew);
        mul_b      = dx_squared;
        state_next = ST_D;
      end
      ST_D: begin
        state_next = ST_DM;
      end
      ST_DM: begin
        mul_a      = tval;
        state_next = ST_S;
      end
      ST_S: begin
        sw_we      = 1'b1;
        state_next = is_last ? ST_B0 : ST_RD;
      end
      ST_B0: begin
        state_next = ST_B1;
      end
      ST_B1: begin
        psi_we     = 1'b1;
        psi_wdata  = sw_rd;
        state_next = ST_BRD;
      end
      ST_BRD: begin
        state_next = ST_BW;
      end
      ST_BW: begin
        psi_we     = 1'b1;
        psi_wdata  = b_val;
        state_next = is_first ? ST_CRD : ST_BRD;
      end
      ST_CRD: begin
        state_next = ST_COUT;
      end
      ST_COUT: begin
        if (out_load) begin
          state_next = is_last ? ST_IDLE : ST_CRD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        j <= '0;
        n <= n_clamp;
      end
      ST_RD2: begin
        pleft <= is_first ? '0 : $signed(psi_rd);
        zsrc  <= forward_mode ? $signed(zp_rd) : $signed(zbp_rd);
        zpold <= $signed(zp_rd);
      end
      ST_Z: begin
        znew <= z_val;
      end
      ST_D: begin
        tval <= MA_W'(is_first ? d_full : d_full - ACC_W'(swprev));
      end
      ST_S: begin
        swprev <= sw_val;
        if (!is_last) begin
          j <= j + AW'(1);
        end
      end
      ST_B1: begin
        psinext <= $signed(sw_rd);
        j       <= j - AW'(1);
      end
      ST_BW: begin
        psinext <= b_val;
        if (!is_first) begin
          j <= j - AW'(1);
        end
      end
      ST_COUT: begin
        if (out_load && !is_last) begin
          j <= j + AW'(1);
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (state == ST_COUT && out_load) begin
      o_valid <= 1'b1;
    end else if (res.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_COUT && out_load) begin
      o_idx  <= IDX_W'(j);
      o_psi  <= psi_rd;
      o_zeta <= zp_rd;
      o_last <= is_last;
    end
  end

  assign res.valid     = o_valid;
  assign res.out_index = o_idx;
  assign res.psi_out   = o_psi;
  assign res.zeta_out  = o_zeta;
  assign res.last      = o_last;

  // state memories
  tvs_ram #(.DEPTH(XDIM), .W(VAL_W)) u_psi (
    .clk(clk), .we(psi_we), .waddr(psi_waddr), .wdata(psi_wdata),
    .raddr(psi_raddr), .rdata(psi_rd)
  );

  tvs_ram #(.DEPTH(XDIM), .W(VAL_W)) u_zeta_prev (
    .clk(clk), .we(zp_we), .waddr(zp_waddr), .wdata(zp_wdata),
    .raddr(j), .rdata(zp_rd)
  );

  tvs_ram #(.DEPTH(XDIM), .W(VAL_W)) u_zeta_before_prev (
    .clk(clk), .we(zbp_we), .waddr(zp_waddr), .wdata(zbp_wdata),
    .raddr(j), .rdata(zbp_rd)
  );

  tvs_ram #(.DEPTH(XDIM), .W(VAL_W)) u_sweep (
    .clk(clk), .we(sw_we), .waddr(j), .wdata(sw_wdata),
    .raddr(j), .rdata(sw_rd)
  );

  // shared multiplier
  tvs_mul u_mul (
    .clk(clk), .a(mul_a), .b(mul_b), .prod(prod), .neg(prod_neg)
  );

  // point counter stays inside the active range during a step
  a_j_range: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (CW'(j) < n))
    else $error("point counter beyond point count");

  // the final result returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COUT && out_load && is_last) |=> (state == ST_IDLE && o_last))
    else $error("step did not end on last point");

  // sweep memory is written only by forward elimination
  a_sw_write: assert property (@(posedge clk) disable iff (rst)
    sw_we |-> (state == ST_S))
    else $error("unexpected sweep write");

  // a result is loaded only while the output register can take it
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (o_valid && !res.ready && state == ST_COUT) |=> (state == ST_COUT))
    else $error("result overwritten while stalled");

endmodule

// ===== sim/bounded_vorticity_step_tridiag_solver_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_vorticity_step_tridiag_solver_tb
// Drives load and step items through the solver under random bursts, gaps
// and output stalls. A local fixed-point predictor of the vorticity update
// and the tridiagonal sweep gives the expected points of every step, and
// each returned point is compared field by field.
// ----------------------------------------------------------------------------
module bounded_vorticity_step_tridiag_solver_tb;
  import tvs_pkg::*;

  localparam int NPTS = 64;
  localparam int IDLE_LIMIT = 4000;

  typedef struct packed {
    logic [5:0]  out_index;
    logic [31:0] psi_out;
    logic [31:0] zeta_out;
    logic        last;
  } grid_point_t;

  logic clk;
  logic rst;

  tvs_cfg_if cfg_ch ();
  tvs_cmd_if cmd_ch ();
  tvs_res_if res_ch ();

  bounded_vorticity_step_tridiag_solver #(.XDIM(NPTS)) u_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  // predictor state and configuration
  logic signed [31:0] psi_mem   [NPTS];
  logic signed [31:0] zeta_now  [NPTS];
  logic signed [31:0] zeta_old  [NPTS];
  logic signed [31:0] elim_mem  [NPTS];
  longint unsigned    off_mag   [NPTS];
  logic [30:0]        ratio_reg;
  logic [31:0]        dx2_reg;
  logic               fwd_reg;
  logic [6:0]         npts_reg;

  grid_point_t expected_points [$];
  int mismatches;
  int burst_left;
  int idle_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // round a * b / 2^s, ties away from zero
  function automatic longint round_shift(longint a, longint unsigned b, int s);
    logic [127:0] ua;
    logic [127:0] r;
    ua = (a < 0) ? 128'(-a) : 128'(a);
    r = (ua * 128'(b) + (128'(1) << (s - 1))) >> s;
    return (a < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // apply one accepted command item to the predictor
  function automatic void predict_item(func_t f, logic [5:0] idx,
                                       logic [31:0] z, logic [31:0] p);
    int n;
    longint diff;
    longint d;
    longint t;
    logic signed [31:0] znew [NPTS];
    grid_point_t gp;
    if (f == FUNC_LOAD) begin
      psi_mem[idx] = p;
      zeta_now[idx] = z;
      zeta_old[idx] = z;
      return;
    end
    n = (npts_reg < 3) ? 3 : (npts_reg > NPTS) ? NPTS : int'(npts_reg);
    // vorticity update, psi zero beyond both ends
    for (int j = 0; j < n; j++) begin
      diff = ((j + 1 < n) ? longint'(psi_mem[j + 1]) : 0) -
             ((j > 0) ? longint'(psi_mem[j - 1]) : 0);
      if (fwd_reg)
        znew[j] = clamp32(longint'(zeta_now[j]) - round_shift(diff, ratio_reg, 21));
      else
        znew[j] = clamp32(longint'(zeta_old[j]) - round_shift(diff, ratio_reg, 20));
    end
    for (int j = 0; j < n; j++) begin
      zeta_old[j] = zeta_now[j];
      zeta_now[j] = znew[j];
    end
    // forward elimination
    for (int j = 0; j < n; j++) begin
      d = round_shift(longint'(znew[j]), dx2_reg, 32);
      t = (j == 0) ? d : d - longint'(elim_mem[j - 1]);
      elim_mem[j] = clamp32(-round_shift(t, off_mag[j], 32));
    end
    // back substitution
    psi_mem[n - 1] = elim_mem[n - 1];
    for (int j = n - 2; j >= 0; j--)
      psi_mem[j] = clamp32(longint'(elim_mem[j]) +
                           round_shift(longint'(psi_mem[j + 1]), off_mag[j], 32));
    for (int j = 0; j < n; j++) begin
      gp.out_index = 6'(j);
      gp.psi_out = psi_mem[j];
      gp.zeta_out = znew[j];
      gp.last = (j == n - 1);
      expected_points.push_back(gp);
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    grid_point_t got;
    grid_point_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.out_index, res_ch.psi_out, res_ch.zeta_out, res_ch.last};
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected point: idx %0d psi %h zeta %h last %b",
                   got.out_index, got.psi_out, got.zeta_out, got.last);
      end else begin
        want = expected_points.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"point mismatch: exp idx %0d psi %h zeta %h last %b",
                      " / got idx %0d psi %h zeta %h last %b"},
                     want.out_index, want.psi_out, want.zeta_out, want.last,
                     got.out_index, got.psi_out, got.zeta_out, got.last);
        end
      end
    end
  end

  // receiver stall pattern: phases of always ready, light and heavy stalls
  always @(posedge clk) begin
    int phase;
    if (rst) begin
      phase = 0;
      res_ch.ready <= 1'b1;
    end else begin
      if ($urandom_range(0, 63) == 0) phase = $urandom_range(0, 2);
      case (phase)
        0: res_ch.ready <= 1'b1;
        1: res_ch.ready <= ($urandom_range(0, 3) != 0);
        default: res_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // watchdog on cycles with no accepted item anywhere
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("bounded_vorticity_step_tridiag_solver: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // send one command item, valid stays high inside a burst
  task automatic send_item(func_t f, logic [5:0] idx, logic [31:0] z, logic [31:0] p);
    cmd_ch.valid <= 1'b1;
    cmd_ch.func <= f;
    cmd_ch.point_index <= idx;
    cmd_ch.zeta_value <= z;
    cmd_ch.psi_value <= p;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    predict_item(f, idx, z, p);
    if (burst_left == 0) begin
      cmd_ch.valid <= 1'b0;
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 6);
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // hold the sender until every expected point has come back
  task automatic drain_points();
    if (cmd_ch.valid) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    burst_left = 0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= r;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (r)
      REG_STEP_RATIO:   ratio_reg = value[30:0];
      REG_DX_SQUARED:   dx2_reg = value;
      REG_FORWARD_MODE: fwd_reg = value[0];
      default:          npts_reg = value[6:0];
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(logic [31:0] ratio, logic [31:0] dx2, logic fwd,
                            logic [6:0] npts);
    drain_points();
    write_reg(REG_STEP_RATIO, ratio);
    write_reg(REG_DX_SQUARED, dx2);
    write_reg(REG_FORWARD_MODE, {31'b0, fwd});
    write_reg(REG_POINTS_IN_USE, {25'b0, npts});
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      default: return $urandom;
    endcase
  endfunction

  // every point gets a value so no step reads an unwritten entry
  task automatic test_load_all();
    for (int k = 0; k < NPTS; k++)
      send_item(FUNC_LOAD, 6'(k), rand_value(), rand_value());
  endtask

  // field extremes, both modes, point count clamping
  task automatic test_directed();
    set_config(32'h0010_0000, 32'h0010_0000, 1'b1, 7'd3);
    send_item(FUNC_LOAD, 6'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(FUNC_LOAD, 6'd1, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(FUNC_LOAD, 6'd2, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(FUNC_LOAD, 6'd63, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(FUNC_STEP, 6'd0, 32'h0, 32'h0);
    send_item(FUNC_STEP, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 7'd0);
    send_item(FUNC_STEP, 6'd0, 32'h0, 32'h0);
    send_item(FUNC_STEP, 6'd0, 32'h0, 32'h0);
    set_config(32'h0, 32'h0, 1'b1, 7'd127);
    send_item(FUNC_STEP, 6'd0, 32'h0, 32'h0);
    set_config(32'h0008_0000, 32'h0100_0000, 1'b0, 7'd64);
    send_item(FUNC_LOAD, 6'd63, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(FUNC_STEP, 6'd0, 32'h0, 32'h0);
    set_config(32'h7FFF_FFFF, 32'h0000_0001, 1'b1, 7'd4);
    send_item(FUNC_STEP, 6'd0, 32'h0, 32'h0);
    send_item(FUNC_STEP, 6'd0, 32'h0, 32'h0);
  endtask

  // random phases, mostly short grids, a few full ones
  task automatic test_random();
    logic [6:0] npts;
    for (int ph = 0; ph < 8; ph++) begin
      npts = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(60, 127))
                                         : 7'($urandom_range(0, 16));
      set_config($urandom_range(0, 1) ? 32'($urandom_range(0, 1 << 22)) : $urandom,
                 $urandom_range(0, 1) ? 32'($urandom_range(0, 1 << 26)) : $urandom,
                 1'($urandom_range(0, 1)), npts);
      for (int k = 0; k < 16; k++) begin
        if ($urandom_range(0, 2) == 0)
          send_item(FUNC_STEP, 6'($urandom), $urandom, $urandom);
        else
          send_item(FUNC_LOAD, 6'($urandom), rand_value(), rand_value());
      end
    end
  endtask

  initial begin
    for (longint unsigned k = 0; k < NPTS; k++) begin
      off_mag[k] = (((k + 1) << 32) + (k + 2) / 2) / (k + 2);
      psi_mem[k] = '0;
      zeta_now[k] = '0;
      zeta_old[k] = '0;
      elim_mem[k] = '0;
    end
    ratio_reg = 31'd1048576;
    dx2_reg = 32'd1048576;
    fwd_reg = 1'b1;
    npts_reg = 7'd64;
    mismatches = 0;
    burst_left = 0;
    cmd_ch.valid = 1'b0;
    cmd_ch.func = FUNC_LOAD;
    cmd_ch.point_index = '0;
    cmd_ch.zeta_value = '0;
    cmd_ch.psi_value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_STEP_RATIO;
    cfg_ch.data = '0;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_load_all();
    test_directed();
    test_random();
    drain_points();
    repeat (20) @(posedge clk);

    if (mismatches == 0 && expected_points.size() == 0)
      $display("bounded_vorticity_step_tridiag_solver: match");
    else
      $display("bounded_vorticity_step_tridiag_solver: mismatch");
    $finish;
  end

endmodule
